>>> hdl/thd_pkg.sv
// Shared types and constants of the two-level Huffman decoder.
package thd_pkg;

    localparam int PRIMARY_BITS   = 9;
    localparam int SECONDARY_BITS = 7;
    localparam int PRIMARY_SIZE   = 1 << PRIMARY_BITS;
    localparam int SECONDARY_SIZE = 1 << SECONDARY_BITS;
    localparam int ENTRY_W        = 13;   // {value[8:0], length[3:0]}
    localparam int BUF_W          = 24;
    localparam int HELD_W         = 5;

    localparam logic [8:0] MARKER_RESET = 9'd256;

    localparam logic FUNC_TABLE = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    typedef enum logic [1:0] {
        KIND_SYMBOL  = 2'd0,
        KIND_END     = 2'd1,
        KIND_CORRUPT = 2'd2,
        KIND_NOEND   = 2'd3
    } t_kind;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic idle;
        logic pend_valid;
    } t_ctl_status;

endpackage

>>> hdl/thd_table_mem.sv
// Decode table memory: one write port, one registered read port.
module thd_table_mem import thd_pkg::*; #(
    parameter int DEPTH = 4608,
    parameter int AW    = 13
) (
    input  logic               i_clk,
    input  t_mem_ctl           i_ctl,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold the read data between reads
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/thd_ctrl.sv
// Decode sequencer: bit buffer, table lookups, pending result and output register.
module thd_ctrl import thd_pkg::*; #(
    parameter int SECONDARY_TABLES = 32,
    parameter int DEPTH            = 4608,
    parameter int AW               = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [8:0]         i_end_marker,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  logic               i_func,
    input  logic [12:0]        i_table_addr,
    input  logic [8:0]         i_entry_value,
    input  logic [3:0]         i_entry_length,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [7:0]         o_m_symbol,
    output logic [1:0]         o_m_kind,
    output logic               o_m_last,
    output t_mem_ctl           o_mem_ctl,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [ENTRY_W-1:0] o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [ENTRY_W-1:0] i_mem_rdata,
    output t_ctl_status        o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EVAL1,
        S_EVAL2,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [HELD_W-1:0]  r_held, n_held;
    logic               r_stopped, n_stopped;
    logic               r_fin, n_fin;
    logic               r_pend_valid, n_pend_valid;
    logic [7:0]         r_pend_sym, n_pend_sym;
    t_kind              r_pend_kind, n_pend_kind;
    logic               r_m_valid, n_m_valid;
    logic [7:0]         r_m_sym, n_m_sym;
    t_kind              r_m_kind, n_m_kind;
    logic               r_m_last, n_m_last;

    // decode decisions
    t_state             to_state;
    logic               em;
    t_kind              em_kind;
    logic [7:0]         em_sym;
    logic               cons_en;
    logic [HELD_W-1:0]  cons_n;
    logic               rd_pri;
    logic               rd_sec;

    logic [BUF_W+15:0]  window;
    logic [8:0]         peek_pri;
    logic [6:0]         peek_sec;
    logic [3:0]         q_len;
    logic [8:0]         q_val;
    logic [7:0]         q_k;
    logic               k_bad;
    logic [16:0]        sec_wide;
    logic [AW+12:0]     waddr_ext;
    logic               waddr_ok;
    logic               can_push;
    logic               stall;
    logic [HELD_W-1:0]  cons_eff;
    logic [HELD_W-1:0]  held_after;

    // bits above r_held are always zero, so the window needs no mask
    assign window   = {r_buf, 16'd0};
    assign peek_pri = 9'(window >> (6'(r_held) + 6'd7));
    assign peek_sec = 7'(window >> r_held);

    assign q_len    = i_mem_rdata[3:0];
    assign q_val    = i_mem_rdata[12:4];
    assign q_k      = q_val[7:0];
    assign k_bad    = (q_k == 8'd0) || (9'(q_k) > 9'(SECONDARY_TABLES));
    assign sec_wide = 17'({q_k, peek_sec}) + 17'(PRIMARY_SIZE - SECONDARY_SIZE);

    assign waddr_ext = (AW + 13)'(i_table_addr);
    assign waddr_ok  = 17'(i_table_addr) < 17'(DEPTH);

    assign can_push  = !r_m_valid || i_m_ready;

    always_comb begin
        to_state = r_state;
        em       = 1'b0;
        em_kind  = KIND_SYMBOL;
        em_sym   = 8'd0;
        cons_en  = 1'b0;
        cons_n   = '0;
        rd_pri   = 1'b0;
        rd_sec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                to_state = S_IDLE;
            end
            S_LOOK: begin
                if (!r_fin && r_held < HELD_W'(PRIMARY_BITS)) begin
                    to_state = S_FINISH;
                end else if (r_fin && r_held == '0) begin
                    em       = 1'b1;
                    em_kind  = KIND_NOEND;
                    to_state = S_FINISH;
                end else begin
                    rd_pri   = 1'b1;
                    to_state = S_EVAL1;
                end
            end
            S_EVAL1: begin
                if (q_len == 4'd0) begin
                    em       = 1'b1;
                    em_kind  = KIND_CORRUPT;
                    to_state = S_FINISH;
                end else if (!q_val[8]) begin
                    em       = 1'b1;
                    em_sym   = q_val[7:0];
                    cons_en  = 1'b1;
                    cons_n   = (q_len > 4'(PRIMARY_BITS)) ? HELD_W'(PRIMARY_BITS)
                                                          : HELD_W'(q_len);
                    to_state = S_LOOK;
                end else if (q_val == i_end_marker) begin
                    em       = 1'b1;
                    em_kind  = KIND_END;
                    to_state = S_FINISH;
                end else if (k_bad) begin
                    em       = 1'b1;
                    em_kind  = KIND_CORRUPT;
                    to_state = S_FINISH;
                end else if (!r_fin &&
                             r_held < HELD_W'(PRIMARY_BITS + SECONDARY_BITS)) begin
                    to_state = S_FINISH;
                end else begin
                    rd_sec   = 1'b1;
                    to_state = S_EVAL2;
                end
            end
            S_EVAL2: begin
                if (q_len == 4'd0) begin
                    em       = 1'b1;
                    em_kind  = KIND_CORRUPT;
                    to_state = S_FINISH;
                end else if (q_val == i_end_marker) begin
                    em       = 1'b1;
                    em_kind  = KIND_END;
                    to_state = S_FINISH;
                end else if (q_val[8]) begin
                    em       = 1'b1;
                    em_kind  = KIND_CORRUPT;
                    to_state = S_FINISH;
                end else begin
                    em       = 1'b1;
                    em_sym   = q_val[7:0];
                    cons_en  = 1'b1;
                    cons_n   = HELD_W'(PRIMARY_BITS) +
                               ((q_len > 4'(SECONDARY_BITS)) ? HELD_W'(SECONDARY_BITS)
                                                             : HELD_W'(q_len));
                    to_state = S_LOOK;
                end
            end
            S_FINISH: begin
                to_state = S_IDLE;
            end
            default: begin
                to_state = S_IDLE;
            end
        endcase
    end

    assign cons_eff   = (cons_n > r_held) ? r_held : cons_n;
    assign held_after = r_held - cons_eff;

    // a new result or the final flush needs the output register once a result is pending
    assign stall = r_pend_valid && !can_push &&
                   (em || r_state == S_FINISH);

    always_comb begin
        n_state      = r_state;
        n_buf        = r_buf;
        n_held       = r_held;
        n_stopped    = r_stopped;
        n_fin        = r_fin;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_kind  = r_pend_kind;
        n_m_valid    = r_m_valid && !i_m_ready;
        n_m_sym      = r_m_sym;
        n_m_kind     = r_m_kind;
        n_m_last     = r_m_last;
        o_mem_ctl    = '0;
        o_mem_waddr  = waddr_ext[AW-1:0];
        o_mem_wdata  = {i_entry_value, i_entry_length};
        o_mem_raddr  = rd_sec ? sec_wide[AW-1:0] : AW'(peek_pri);

        if (r_state == S_IDLE) begin
            if (i_s_valid) begin
                if (i_func == FUNC_TABLE) begin
                    o_mem_ctl.we = waddr_ok;
                end else if (r_stopped) begin
                    // drop the byte; the final one reopens the stream
                    if (i_last_byte) begin
                        n_buf     = '0;
                        n_held    = '0;
                        n_stopped = 1'b0;
                    end
                end else begin
                    n_buf   = {r_buf[BUF_W-9:0], i_data_byte};
                    n_held  = r_held + HELD_W'(8);
                    n_fin   = i_last_byte;
                    n_state = S_LOOK;
                end
            end
        end else if (!stall) begin
            n_state      = to_state;
            o_mem_ctl.re = rd_pri || rd_sec;
            if (em) begin
                if (r_pend_valid) begin
                    n_m_valid = 1'b1;
                    n_m_sym   = r_pend_sym;
                    n_m_kind  = r_pend_kind;
                    n_m_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_sym   = em_sym;
                n_pend_kind  = em_kind;
                if (em_kind != KIND_SYMBOL) begin
                    n_stopped = 1'b1;
                end
            end
            if (cons_en) begin
                n_held = held_after;
                n_buf  = r_buf & ~({BUF_W{1'b1}} << held_after);
            end
            if (r_state == S_FINISH) begin
                if (r_pend_valid) begin
                    n_m_valid = 1'b1;
                    n_m_sym   = r_pend_sym;
                    n_m_kind  = r_pend_kind;
                    n_m_last  = 1'b1;
                end
                n_pend_valid = 1'b0;
                if (r_fin) begin
                    n_buf     = '0;
                    n_held    = '0;
                    n_stopped = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_buf        <= '0;
            r_held       <= '0;
            r_stopped    <= 1'b0;
            r_fin        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_buf        <= n_buf;
            r_held       <= n_held;
            r_stopped    <= n_stopped;
            r_fin        <= n_fin;
            r_pend_valid <= n_pend_valid;
            r_m_valid    <= n_m_valid;
        end
        r_pend_sym  <= n_pend_sym;
        r_pend_kind <= n_pend_kind;
        r_m_sym     <= n_m_sym;
        r_m_kind    <= n_m_kind;
        r_m_last    <= n_m_last;
    end

    assign o_s_ready  = (r_state == S_IDLE);
    assign o_m_valid  = r_m_valid;
    assign o_m_symbol = r_m_sym;
    assign o_m_kind   = r_m_kind;
    assign o_m_last   = r_m_last;

    assign o_status.idle       = (r_state == S_IDLE);
    assign o_status.pend_valid = r_pend_valid;

endmodule

>>> hdl/two_level_huffman_decoder.sv
// Top level of the two-level table-driven Huffman decoder.
//
// Usage: load the decode table with table-write beats (tuser 0): the primary
// table lies at 0..511, secondary table k at 512 + (k-1)*128; writes beyond
// the table are dropped. Then send stream beats (tuser 1), first code bit in
// the MSB of the byte, tlast on the final byte. Each result beat carries a
// symbol and a kind (symbol, end marker, corrupt stream, input ended without
// marker); tlast marks the final result caused by one input beat.
// Table-write beats are taken while idle. After a stream beat is accepted, each
// code takes a primary lookup, plus a secondary lookup for a two-level code, and
// a final check and a closing step end the byte; the lookups go one after
// another through the single registered read port of the table memory.
// The first result of a byte appears once the next code is decoded, or at the
// closing step, as each result is held back until it is known whether it is
// the last one.
// Reset clears the bit buffer, the stop flag and the end marker register
// (back to 256); the table contents are undefined until written.
// A stalled receiver holds the result in the output register; decoding pauses
// when a further result would need it, and input is accepted only between bytes.
module two_level_huffman_decoder import thd_pkg::*; #(
    parameter int SECONDARY_TABLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [12:0] table_addr, [21:13] entry_value, [25:22] entry_length,
    // [33:26] data_byte, [39:34] zero
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // [0] func
    input  logic        s_axis_tlast,   // last_byte
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] symbol
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = PRIMARY_SIZE + SECONDARY_TABLES * SECONDARY_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic [8:0]         r_end_marker;
    t_mem_ctl           mem_ctl;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    t_ctl_status        status;
    logic               cfg_write;

    // register 0 sits at byte address 0; address 4 is outside the map
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == 1'b0) ? {23'd0, r_end_marker} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker <= MARKER_RESET;
        end else if (cfg_write && paddr[2] == 1'b0) begin
            r_end_marker <= pwdata[8:0];
        end
    end

    thd_table_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    thd_ctrl #(
        .SECONDARY_TABLES (SECONDARY_TABLES),
        .DEPTH            (DEPTH),
        .AW               (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_end_marker   (r_end_marker),
        .i_s_valid      (s_axis_tvalid),
        .o_s_ready      (s_axis_tready),
        .i_func         (s_axis_tuser),
        .i_table_addr   (s_axis_tdata[12:0]),
        .i_entry_value  (s_axis_tdata[21:13]),
        .i_entry_length (s_axis_tdata[25:22]),
        .i_data_byte    (s_axis_tdata[33:26]),
        .i_last_byte    (s_axis_tlast),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_m_symbol     (m_axis_tdata),
        .o_m_kind       (m_axis_tuser),
        .o_m_last       (m_axis_tlast),
        .o_mem_ctl      (mem_ctl),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_status       (status)
    );

    // no result may be left pending once the block takes input again
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.idle |-> !status.pend_valid)
        else $error("pending result left behind at idle");

    // a stop result always ends the run of results of its beat
    a_stop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_SYMBOL) |-> m_axis_tlast)
        else $error("stop result without tlast");

    // only symbol results carry data
    a_stop_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_SYMBOL) |-> (m_axis_tdata == 8'd0))
        else $error("stop result with non-zero symbol");

    // table writes only happen between bytes, never against a lookup
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.we |-> (status.idle && !mem_ctl.re))
        else $error("table write during decoding");

endmodule

>>> verif/two_level_huffman_decoder_test.sv
// Self-checking testbench for the two-level table-driven Huffman decoder.
`timescale 1ns / 1ps

module two_level_huffman_decoder_test import thd_pkg::*;;

    localparam int N_TABLES       = 32;
    localparam int TABLE_DEPTH    = PRIMARY_SIZE + N_TABLES * SECONDARY_SIZE;
    localparam int POINTER_BASE   = 256;
    localparam int HOLD_CYCLES    = 40;     // quiet time before a register write and at the end
    localparam int STALL_LIMIT    = 1000;   // cycles without any beat or register access before giving up
    localparam int REPORT_LIMIT   = 10;
    localparam logic [2:0] REG_END_MARKER = 3'd0;

    // One expected result beat.
    typedef struct packed {
        logic [7:0] symbol;
        t_kind      kind;
        logic       last;
    } t_sym_rec;

    // Decoder model plus the queue of symbols it still owes.
    class decode_scoreboard;
        logic [ENTRY_W-1:0] code_table [TABLE_DEPTH];
        logic [BUF_W-1:0]   held_bits;
        int                 bit_count;
        bit                 stopped;
        logic [8:0]         marker;
        t_sym_rec           expected_syms[$];
        int                 fresh_count;
        int                 mismatches;
        int                 seen_kind [4];

        function new();
            foreach (code_table[i]) code_table[i] = '0;
            held_bits   = '0;
            bit_count   = 0;
            stopped     = 1'b0;
            marker      = MARKER_RESET;
            mismatches  = 0;
            foreach (seen_kind[i]) seen_kind[i] = 0;
        endfunction

        function int pending();
            return expected_syms.size();
        endfunction

        function void note_fault(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
        endfunction

        // Look at n bits after skip bits from the oldest held bit; pad with zeros.
        function logic [31:0] window(int skip, int n);
            logic [63:0] wide;
            logic [31:0] avail;
            avail = 32'(held_bits) & ((32'd1 << bit_count) - 32'd1);
            wide  = {avail, 32'd0};
            wide  = wide >> (32 + bit_count - skip - n);
            return wide[31:0] & ((32'd1 << n) - 32'd1);
        endfunction

        function void drop_bits(int n);
            if (n > bit_count) n = bit_count;
            bit_count -= n;
            held_bits &= BUF_W'((32'd1 << bit_count) - 32'd1);
        endfunction

        function void post_symbol(logic [7:0] sym, t_kind kind);
            t_sym_rec rec;
            rec.symbol = sym;
            rec.kind   = kind;
            rec.last   = 1'b0;
            expected_syms = {expected_syms, rec};
            fresh_count++;
            if (kind != KIND_SYMBOL) stopped = 1'b1;
        endfunction

        // Note an accepted input beat and queue the results it causes.
        // Returns 0 for a stream byte that a stopped stream drops.
        function bit absorb_beat(logic func, logic [12:0] addr, logic [8:0] val,
                                 logic [3:0] len, logic [7:0] data, logic fin);
            logic [ENTRY_W-1:0] ent;
            logic [8:0]         v;
            logic [3:0]         l;
            int                 k;
            bit                 live;
            if (func == FUNC_TABLE) begin
                if (int'(addr) < TABLE_DEPTH) code_table[addr] = {val, len};
                return 1'b1;
            end
            fresh_count = 0;
            live = !stopped;
            if (!stopped) begin
                held_bits = {held_bits[BUF_W-9:0], data};
                bit_count += 8;
            end
            while (!stopped) begin
                if (!fin && bit_count < PRIMARY_BITS) break;
                if (fin && bit_count == 0) begin
                    post_symbol(8'd0, KIND_NOEND);
                    break;
                end
                ent = code_table[int'(window(0, PRIMARY_BITS))];
                v = ent[12:4];
                l = ent[3:0];
                if (l == 4'd0) begin
                    post_symbol(8'd0, KIND_CORRUPT);
                    break;
                end
                if (v < POINTER_BASE) begin
                    post_symbol(v[7:0], KIND_SYMBOL);
                    drop_bits(l > PRIMARY_BITS ? PRIMARY_BITS : int'(l));
                    continue;
                end
                if (v == marker) begin
                    post_symbol(8'd0, KIND_END);
                    break;
                end
                k = int'(v) - POINTER_BASE;
                if (k < 1 || k > N_TABLES) begin
                    post_symbol(8'd0, KIND_CORRUPT);
                    break;
                end
                if (!fin && bit_count < PRIMARY_BITS + SECONDARY_BITS) break;
                ent = code_table[PRIMARY_SIZE + (k - 1) * SECONDARY_SIZE
                                 + int'(window(PRIMARY_BITS, SECONDARY_BITS))];
                v = ent[12:4];
                l = ent[3:0];
                if (l == 4'd0) begin
                    post_symbol(8'd0, KIND_CORRUPT);
                    break;
                end
                if (v == marker) begin
                    post_symbol(8'd0, KIND_END);
                    break;
                end
                if (v >= POINTER_BASE) begin
                    post_symbol(8'd0, KIND_CORRUPT);
                    break;
                end
                post_symbol(v[7:0], KIND_SYMBOL);
                drop_bits(PRIMARY_BITS + (l > SECONDARY_BITS ? SECONDARY_BITS : int'(l)));
            end
            if (fin) begin
                held_bits = '0;
                bit_count = 0;
                stopped   = 1'b0;
            end
            if (fresh_count > 0) expected_syms[expected_syms.size() - 1].last = 1'b1;
            return live;
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        function void match_result(logic [7:0] sym, logic [1:0] kind, logic last);
            t_sym_rec want;
            if (expected_syms.size() == 0) begin
                note_fault($sformatf("unexpected result symbol %0d kind %0d last %0d",
                                     sym, kind, last));
                return;
            end
            want = expected_syms.pop_front();
            seen_kind[int'(want.kind)]++;
            if (sym !== want.symbol || kind !== want.kind || last !== want.last)
                note_fault($sformatf(
                    "expected symbol %0d kind %0d last %0d, got symbol %0d kind %0d last %0d",
                    want.symbol, want.kind, want.last, sym, kind, last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    decode_scoreboard sb;
    int send_idle;      // percent of cycles the sender holds back
    int recv_idle;      // percent of cycles the receiver stalls
    int live_beats;     // accepted beats that the block acts on
    int streams_sent;
    int stall_cycles;

    two_level_huffman_decoder #(
        .SECONDARY_TABLES(N_TABLES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check every accepted beat, then roll the stall for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: any beat or register access counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one input beat, idling at random first, and hold it until taken.
    // tvalid is left high so that a following beat goes out back to back.
    task automatic send_beat(input logic func, input logic [12:0] addr, input logic [8:0] val,
                             input logic [3:0] len, input logic [7:0] data, input logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tlast  <= fin;
        s_axis_tdata  <= {6'd0, data, len, val, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (sb.absorb_beat(func, addr, val, len, data, fin)) live_beats++;
    endtask

    // Table-write beat; the stream fields ride along with random content.
    task automatic write_entry(input logic [12:0] addr, input logic [8:0] val,
                               input logic [3:0] len);
        send_beat(FUNC_TABLE, addr, val, len, 8'($urandom), 1'($urandom));
    endtask

    // Stream beat; the table fields ride along with random content.
    task automatic send_byte(input logic [7:0] data, input logic fin);
        send_beat(FUNC_DATA, 13'($urandom), 9'($urandom), 4'($urandom), data, fin);
        if (fin) streams_sent++;
    endtask

    // Drop tvalid, drain every owed result, then give the block time to go idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    // Write the end marker register, then read it straight back.
    task automatic program_marker(input logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_END_MARKER;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.marker = value;
        // keep psel high: the read setup follows directly
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(value))
            sb.note_fault($sformatf("end marker read back %0d, written %0d", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Secondary tables that hold real content; valid pointers only ever aim at these.
    function automatic int table_pick();
        case ($urandom_range(2))
            0:       return 1;
            1:       return 2;
            default: return N_TABLES;
        endcase
    endfunction

    // Draw one table entry for a code of code_len bits. Mostly plain symbols, with a
    // sprinkling of pointers, end markers, unused entries, stray values and
    // over-long lengths.
    function automatic logic [12:0] pick_entry(input bit secondary, input int code_len);
        int         roll;
        logic [8:0] val;
        logic [3:0] len;
        roll = $urandom_range(99);
        val  = 9'($urandom_range(255));
        len  = 4'(code_len);
        if (!secondary) begin
            if (roll >= 97) begin
                len = 4'($urandom_range(10, 15));
            end else if (roll >= 95) begin
                len = 4'd0;
            end else if (roll >= 93) begin
                // pointer to no table at all
                val = ($urandom_range(1) != 0) ? 9'(POINTER_BASE)
                                               : 9'($urandom_range(POINTER_BASE + N_TABLES + 1,
                                                                   511));
            end else if (roll >= 90) begin
                val = sb.marker;
            end else if (roll >= 80) begin
                val = 9'(POINTER_BASE + table_pick());
                len = 4'($urandom_range(1, 15));
            end
        end else begin
            if (roll >= 96) begin
                len = 4'($urandom_range(8, 15));
            end else if (roll >= 93) begin
                len = 4'd0;
            end else if (roll >= 90) begin
                val = 9'($urandom_range(256, 511));
            end else if (roll >= 86) begin
                val = sb.marker;
            end
        end
        return {val, len};
    endfunction

    // Fill a whole table with a random prefix code: each code of length L covers
    // an aligned block of 2^(bits-L) entries.
    task automatic load_code_table(input int base, input int bits, input bit secondary);
        int          idx;
        int          low_len;
        int          code_len;
        int          span;
        int          j;
        logic [12:0] ent;
        idx = 0;
        while (idx < (1 << bits)) begin
            low_len = bits;
            span    = 1;
            while (low_len > 1 && idx % (span * 2) == 0) begin
                span    = span * 2;
                low_len = low_len - 1;
            end
            if (low_len < (secondary ? 2 : 3)) low_len = secondary ? 2 : 3;
            code_len = $urandom_range(low_len, bits);
            span     = 1 << (bits - code_len);
            ent      = pick_entry(secondary, code_len);
            for (j = 0; j < span; j++) write_entry(13'(base + idx + j), ent[12:4], ent[3:0]);
            idx = idx + span;
        end
    endtask

    // Overwrite a few entries at random; short lengths here make the densest bytes.
    task automatic scatter_entries(input int count);
        int          roll;
        logic [12:0] ent;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                ent = pick_entry(1'b0, $urandom_range(1, PRIMARY_BITS));
                write_entry(13'($urandom_range(PRIMARY_SIZE - 1)), ent[12:4], ent[3:0]);
            end else if (roll < 90) begin
                ent = pick_entry(1'b1, $urandom_range(1, SECONDARY_BITS));
                write_entry(13'(PRIMARY_SIZE + (table_pick() - 1) * SECONDARY_SIZE
                                + $urandom_range(SECONDARY_SIZE - 1)), ent[12:4], ent[3:0]);
            end else begin
                // beyond the table: the block must drop it
                write_entry(13'($urandom_range(TABLE_DEPTH, 8191)), 9'($urandom),
                            4'($urandom));
            end
        end
    endtask

    // Aim a three-byte stream at one primary entry, then put the entry back.
    task automatic probe_entry(input logic [8:0] idx, input logic [8:0] val,
                               input logic [3:0] len);
        logic [12:0] saved;
        saved = sb.code_table[idx];
        write_entry(13'(idx), val, len);
        send_byte(idx[8:1], 1'b0);
        send_byte({idx[0], 7'($urandom)}, 1'b0);
        send_byte(8'($urandom), 1'b1);
        write_entry(13'(idx), saved[12:4], saved[3:0]);
    endtask

    // One stream of random bytes with tlast on its final byte; mostly short runs.
    task automatic random_stream();
        int         n_bytes;
        int         roll;
        int         i;
        logic [7:0] data;
        roll = $urandom_range(99);
        if (roll < 10)      n_bytes = 1;
        else if (roll < 90) n_bytes = $urandom_range(2, 8);
        else                n_bytes = $urandom_range(9, 24);
        for (i = 0; i < n_bytes; i++) begin
            roll = $urandom_range(99);
            if (roll < 8)       data = 8'h00;
            else if (roll < 16) data = 8'hFF;
            else                data = 8'($urandom);
            send_byte(data, i == n_bytes - 1);
        end
    endtask

    // Streams with occasional table edits in between, until enough live beats.
    task automatic run_random(input int target);
        int start;
        start = live_beats;
        while (live_beats - start < target) begin
            if ($urandom_range(99) < 15) scatter_entries($urandom_range(1, 3));
            random_stream();
        end
    endtask

    initial begin
        sb           = new();
        live_beats   = 0;
        streams_sent = 0;
        send_idle    = 31;
        recv_idle    = 55;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load the full primary table and three secondary tables under the reset
        // marker; every entry the stream can reach is written before it is read.
        load_code_table(0, PRIMARY_BITS, 1'b0);
        load_code_table(PRIMARY_SIZE, SECONDARY_BITS, 1'b1);
        load_code_table(PRIMARY_SIZE + SECONDARY_SIZE, SECONDARY_BITS, 1'b1);
        load_code_table(PRIMARY_SIZE + (N_TABLES - 1) * SECONDARY_SIZE, SECONDARY_BITS, 1'b1);

        // Directed: unused entry then dropped bytes, pointer to a missing table,
        // pointer value equal to the marker, over-long length, a write past the
        // table, and lone final bytes that need zero padding.
        probe_entry(9'd511, 9'd77, 4'd0);
        probe_entry(9'd0, 9'd300, 4'd9);
        probe_entry(9'($urandom), 9'(POINTER_BASE), 4'd3);
        probe_entry(9'($urandom), 9'd200, 4'd13);
        write_entry(13'h1FFF, 9'h1FF, 4'hF);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h00, 1'b1);
        run_random(90);

        // Marker at the top of its range.
        settle();
        program_marker(9'd511);
        scatter_entries(16);
        run_random(70);

        // Swap the idling: slow sender, eager receiver. The marker now shadows a
        // real pointer to the second table.
        settle();
        send_idle = 55;
        recv_idle = 31;
        program_marker(9'(POINTER_BASE + 2));
        scatter_entries(16);
        run_random(60);

        // Full rate from here on. A marker below 256 loses to primary symbols but
        // still ends the stream from a secondary table.
        settle();
        send_idle = 0;
        recv_idle = 0;
        program_marker(9'd65);
        scatter_entries(12);
        run_random(50);

        settle();
        program_marker(9'd300);
        scatter_entries(12);
        run_random(40);

        settle();
        $display("run: %0d live input beats in %0d streams, five end marker settings",
                 live_beats, streams_sent);
        $display("run: checked %0d symbols, %0d end, %0d corrupt, %0d unterminated; %0d faults",
                 sb.seen_kind[KIND_SYMBOL], sb.seen_kind[KIND_END],
                 sb.seen_kind[KIND_CORRUPT], sb.seen_kind[KIND_NOEND], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/thd_pkg.sv
hdl/thd_table_mem.sv
hdl/thd_ctrl.sv
hdl/two_level_huffman_decoder.sv
verif/two_level_huffman_decoder_test.sv
